### rtl/tmr3oc_pkg.sv
// Package for the three-channel output-compare timer.
// Holds widths, register indexes and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package tmr3oc_pkg;

	localparam int CHANNELS  = 3;
	localparam int STEP_REGS = 3;
	localparam int CNT_W     = 16;
	localparam int PS_W      = 15;
	localparam int CODE_W    = 4;
	localparam int FLAG_W    = 4;
	localparam int IDX_W     = 3;
	localparam int DATA_W    = 16;

	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [PS_W-1:0]   prescale_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [FLAG_W-1:0] flag_t;
	typedef logic [IDX_W-1:0]  reg_idx_t;
	typedef logic [DATA_W-1:0] reg_data_t;

	localparam count_t    CNT_MAX     = '1;
	localparam prescale_t PS_ONES     = '1;
	localparam code_t     PS_MAX_CODE = code_t'(PS_W);

	localparam reg_idx_t REG_PRESCALE   = 3'd0;
	localparam reg_idx_t REG_STEP_ONE   = 3'd1;
	localparam reg_idx_t REG_STEP_TWO   = 3'd2;
	localparam reg_idx_t REG_STEP_THREE = 3'd3;
	localparam reg_idx_t REG_IRQ_ENABLE = 3'd4;

	typedef struct packed {
		code_t                        prescale_code;
		logic [CHANNELS-1:0][CNT_W-1:0] step;
		flag_t                        irq_enable;
	} cfg_t;

	typedef struct packed {
		logic [CHANNELS-1:0] hit;
		count_t              value;
	} step_wr_t;

	typedef struct packed {
		count_t count;
		flag_t  flags;
		logic   irq;
	} result_t;

endpackage

### rtl/timer_three_channel_output_compare.sv
// Three-channel output-compare timer, top level.
// A transaction is registered at the input, processed by tmr3oc_core and its
// result registered at the output. Throughput: one per cycle unless result_stall
// holds the pipeline. Reset clears the counters and flags, sets compare values
// and steps to 0xFFFF; no clearing pass.
// Depends on tmr3oc_pkg, tmr3oc_regs and tmr3oc_core.
`timescale 1ns / 1ps

module timer_three_channel_output_compare (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  tmr3oc_pkg::reg_idx_t  cfg_index,
	input  tmr3oc_pkg::reg_data_t cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  tick,
	input  tmr3oc_pkg::flag_t     clear_mask,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tmr3oc_pkg::count_t    count_now,
	output tmr3oc_pkg::flag_t     status_flags,
	output logic                  irq
);
	import tmr3oc_pkg::*;

	cfg_t     cfg;
	step_wr_t step_wr;
	result_t  res;

	logic  valid_s1;
	logic  tick_s1;
	flag_t clear_s1;
	logic  valid_s2;
	result_t res_s2;
	logic  out_load;
	logic  fire;
	logic  s1_load;

	assign out_load   = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && out_load;
	assign s1_load    = !valid_s1 || fire;
	assign item_stall = !s1_load;

	tmr3oc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.step_wr   (step_wr)
	);

	tmr3oc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_wr    (step_wr),
		.fire       (fire),
		.tick       (tick_s1),
		.clear_mask (clear_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= item_valid;
			end
			if (out_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && s1_load) begin
			tick_s1  <= tick;
			clear_s1 <= clear_mask;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign count_now    = res_s2.count;
	assign status_flags = res_s2.flags;
	assign irq          = res_s2.irq;

endmodule

### rtl/tmr3oc_regs.sv
// Configuration registers of the output-compare timer.
// Decodes the write port into prescale, step and interrupt enable registers.
// Depends on tmr3oc_pkg.
`timescale 1ns / 1ps

module tmr3oc_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  tmr3oc_pkg::reg_idx_t cfg_index,
	input  tmr3oc_pkg::reg_data_t cfg_data,
	output tmr3oc_pkg::cfg_t     cfg,
	output tmr3oc_pkg::step_wr_t step_wr
);
	import tmr3oc_pkg::*;

	code_t prescale_code_q;
	flag_t irq_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_code_q <= '0;
			irq_enable_q    <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_PRESCALE) begin
				prescale_code_q <= cfg_data[CODE_W-1:0];
			end
			if (cfg_index == REG_IRQ_ENABLE) begin
				irq_enable_q <= cfg_data[FLAG_W-1:0];
			end
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_step
		if (i < STEP_REGS) begin : g_reg
			count_t step_q;
			logic   hit;

			assign hit = cfg_write && (cfg_index == reg_idx_t'(REG_STEP_ONE + i));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= CNT_MAX;
				end else if (hit) begin
					step_q <= cfg_data[CNT_W-1:0];
				end
			end

			assign cfg.step[i]    = step_q;
			assign step_wr.hit[i] = hit;
		end else begin : g_fixed
			assign cfg.step[i]    = CNT_MAX;
			assign step_wr.hit[i] = 1'b0;
		end
	end

	assign cfg.prescale_code = prescale_code_q;
	assign cfg.irq_enable    = irq_enable_q;
	assign step_wr.value     = cfg_data[CNT_W-1:0];

endmodule

### rtl/tmr3oc_core.sv
// Timer state and per-transaction next-state logic.
// Prescaler, main counter, compare channels with advance, and status flags.
// Depends on tmr3oc_pkg.
`timescale 1ns / 1ps

module tmr3oc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmr3oc_pkg::cfg_t     cfg,
	input  tmr3oc_pkg::step_wr_t step_wr,
	input  logic                 fire,
	input  logic                 tick,
	input  tmr3oc_pkg::flag_t    clear_mask,
	output tmr3oc_pkg::result_t  res
);
	import tmr3oc_pkg::*;

	prescale_t ps_q;
	prescale_t ps_d;
	prescale_t term;
	count_t    count_q;
	count_t    count_d;
	count_t    cmp_q [CHANNELS];
	count_t    cmp_d [CHANNELS];
	flag_t     flags_q;
	flag_t     flags_d;
	flag_t     set_bits;
	logic      wrap;
	logic      ovf;
	logic [CHANNELS-1:0] match;

	always_comb begin
		term    = PS_ONES >> (PS_MAX_CODE - cfg.prescale_code);
		wrap    = tick && (ps_q >= term);
		ps_d    = ps_q;
		if (tick) begin
			ps_d = wrap ? '0 : ps_q + prescale_t'(1);
		end
		count_d = wrap ? count_q + count_t'(1) : count_q;
		ovf     = wrap && (count_q == CNT_MAX);
		for (int i = 0; i < CHANNELS; i++) begin
			match[i] = wrap && (count_d == cmp_q[i]);
			cmp_d[i] = match[i] ? cmp_q[i] + cfg.step[i] : cmp_q[i];
		end
		set_bits = flag_t'({match, ovf});
		flags_d  = (flags_q & ~clear_mask) | set_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q    <= '0;
			count_q <= '0;
			flags_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				cmp_q[i] <= CNT_MAX;
			end
		end else begin
			if (fire) begin
				ps_q    <= ps_d;
				count_q <= count_d;
				flags_q <= flags_d;
			end
			for (int i = 0; i < CHANNELS; i++) begin
				if (step_wr.hit[i]) begin
					cmp_q[i] <= cmp_q[i] + step_wr.value;
				end else if (fire) begin
					cmp_q[i] <= cmp_d[i];
				end
			end
		end
	end

	assign res.count = count_d;
	assign res.flags = flags_d;
	assign res.irq   = |(flags_d & cfg.irq_enable);

endmodule
